### rtl/core/nups_pkg.sv
// shared types and constants for the nearest unvisited point search block
// no dependencies; imported by nups_ctrl, nups_dp and the top level
package nups_pkg;

	// coordinate and distance widths
	localparam int CW       = 8;
	localparam int D2_W     = 2 * CW + 1;
	localparam int FRAC     = 8;
	localparam int RAD_W    = D2_W + 2 * FRAC;
	localparam int SQ_STEPS = (RAD_W + 1) / 2;
	localparam int RAD_PAD  = 2 * SQ_STEPS;
	localparam int ROOT_W   = SQ_STEPS;
	localparam int REM_W    = ROOT_W + 2;
	localparam int SQ_CNT_W = $clog2(SQ_STEPS);

	// field widths of the result and config beats
	localparam int BOUND_W    = 18;
	localparam int IDX_OUT_W  = 6;
	localparam int DIST_OUT_W = 17;
	localparam int TOT_W      = 32;

	localparam logic [BOUND_W-1:0] BOUND_RESET = 18'd20000;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_MOVE  = 2'd1,
		OP_VISIT = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [CW-1:0] coord_x;
		logic [CW-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic                  found;
		logic [IDX_OUT_W-1:0]  nearest_index;
		logic [DIST_OUT_W-1:0] nearest_dist_sq;
		logic                  marked_visited;
		logic                  table_full;
		logic [TOT_W-1:0]      travelled;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN,
		ST_DRAIN,
		ST_VDONE,
		ST_MV_DIST,
		ST_MV_INIT,
		ST_MV_ITER,
		ST_MV_ACC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic ld_wr;
		logic clr;
		logic rd_en;
		logic sel_item;
		logic sq_init;
		logic sq_step;
		logic acc;
		logic mark;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic ptr_last;
		logic pipe_busy;
		logic sq_last;
	} dp_stat_t;

endpackage

### rtl/core/nups_ctrl.sv
// controller state machine: sequences load, clear, visit scan and move root
// depends on nups_pkg
module nups_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  nups_pkg::op_t       in_op,
	input  nups_pkg::dp_stat_t  stat,
	output nups_pkg::ctrl_cmd_t cmd,
	output logic                busy
);
	import nups_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (in_op)
						OP_LOAD:  state_d = ST_LOAD;
						OP_MOVE:  state_d = ST_MV_DIST;
						OP_VISIT: state_d = stat.cnt_zero ? ST_VDONE : ST_SCAN;
						OP_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.ld_wr = 1'b1;
				cmd.emit  = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clr  = 1'b1;
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.ptr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_VDONE;
				end
			end
			ST_VDONE: begin
				cmd.mark = 1'b1;
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_MV_DIST: begin
				cmd.sel_item = 1'b1;
				state_d      = ST_MV_INIT;
			end
			ST_MV_INIT: begin
				cmd.sq_init = 1'b1;
				state_d     = ST_MV_ITER;
			end
			ST_MV_ITER: begin
				cmd.sq_step = 1'b1;
				if (stat.sq_last) begin
					state_d = ST_MV_ACC;
				end
			end
			ST_MV_ACC: begin
				cmd.acc  = 1'b1;
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/core/nups_dp.sv
// datapath: point table memories, scan pipeline, square root unit, totals
// depends on nups_pkg; driven by nups_ctrl through ctrl_cmd_t
module nups_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nups_pkg::in_item_t          item,
	input  logic                        cfg_we,
	input  logic [nups_pkg::BOUND_W-1:0] cfg_wdata,
	input  nups_pkg::ctrl_cmd_t         cmd,
	output nups_pkg::dp_stat_t          stat,
	output logic                        done,
	output nups_pkg::result_t           result
);
	import nups_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	function automatic logic [D2_W-1:0] sq_dist(
		input logic [CW-1:0] ax,
		input logic [CW-1:0] ay,
		input logic [CW-1:0] bx,
		input logic [CW-1:0] by
	);
		logic [CW-1:0]   dx;
		logic [CW-1:0]   dy;
		logic [2*CW-1:0] sx;
		logic [2*CW-1:0] sy;
		dx = (ax > bx) ? (ax - bx) : (bx - ax);
		dy = (ay > by) ? (ay - by) : (by - ay);
		sx = dx * dx;
		sy = dy * dy;
		return D2_W'(sx) + D2_W'(sy);
	endfunction

	// point table
	logic [2*CW-1:0] pt_mem  [TABLE_DEPTH];
	logic            vis_mem [TABLE_DEPTH];

	// architectural state
	in_item_t         item_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    pos_x_q;
	logic [CW-1:0]    pos_y_q;
	logic [TOT_W-1:0] total_q;
	logic [BOUND_W-1:0] bound_q;

	// scan
	logic [IDX_W-1:0]  ptr_q;
	logic              rd_vld_s1;
	logic [2*CW-1:0]   rd_pt_s1;
	logic              rd_vis_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s2;
	logic              vis_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [D2_W-1:0]   d2_s2;
	logic [BOUND_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              found_q;

	// square root
	logic [RAD_PAD-1:0]  rad_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [SQ_CNT_W-1:0] sq_cnt_q;

	logic                full;
	logic                hit_zero;
	logic [CW-1:0]       a_x;
	logic [CW-1:0]       a_y;
	logic [REM_W-1:0]    rem_sh;
	logic [REM_W-1:0]    trial;
	logic [TOT_W:0]      tot_sum;
	logic [TOT_W-1:0]    tot_next;
	logic [IDX_W+IDX_OUT_W-1:0] idx_wide;
	result_t             res_d;

	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign hit_zero = found_q && (best_q == '0);

	// distance operand: table read during a scan, target during a move
	assign a_x = cmd.sel_item ? item_q.coord_x : rd_pt_s1[2*CW-1:CW];
	assign a_y = cmd.sel_item ? item_q.coord_y : rd_pt_s1[CW-1:0];

	// one root bit per step
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_PAD-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	assign tot_sum  = {1'b0, total_q} + (TOT_W+1)'(root_q);
	assign tot_next = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.ptr_last  = ((CNT_W'(ptr_q) + CNT_W'(1)) == cnt_q);
	assign stat.pipe_busy = rd_vld_s1 | vld_s2;
	assign stat.sq_last   = (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1));

	// memories
	always_ff @(posedge clk) begin
		if (cmd.ld_wr && !full) begin
			pt_mem[cnt_q[IDX_W-1:0]] <= {item_q.coord_x, item_q.coord_y};
		end
		if (cmd.rd_en) begin
			rd_pt_s1 <= pt_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_wr && !full) begin
			vis_mem[cnt_q[IDX_W-1:0]] <= 1'b0;
		end else if (cmd.mark && hit_zero) begin
			vis_mem[best_idx_q] <= 1'b1;
		end
		if (cmd.rd_en) begin
			rd_vis_s1 <= vis_mem[ptr_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		idx_s1 <= ptr_q;
		idx_s2 <= idx_s1;
		vis_s2 <= rd_vis_s1;
		d2_s2  <= sq_dist(a_x, a_y, pos_x_q, pos_y_q);
		if (cmd.emit) begin
			result <= res_d;
		end
		if (cmd.sq_init) begin
			rad_q  <= RAD_PAD'({d2_s2, {(2*FRAC){1'b0}}});
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			rad_q <= {rad_q[RAD_PAD-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			total_q    <= '0;
			bound_q    <= BOUND_RESET;
			ptr_q      <= '0;
			rd_vld_s1  <= 1'b0;
			vld_s2     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
			found_q    <= 1'b0;
			sq_cnt_q   <= '0;
			done       <= 1'b0;
		end else begin
			done      <= cmd.emit;
			rd_vld_s1 <= cmd.rd_en;
			vld_s2    <= rd_vld_s1;
			if (cfg_we) begin
				bound_q <= cfg_wdata;
			end
			if (cmd.ld_wr && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.clr) begin
				cnt_q <= '0;
			end
			if (cmd.accept) begin
				ptr_q   <= '0;
				best_q  <= bound_q;
				found_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
				// keep the first strict minimum
				if (vld_s2 && !vis_s2 && (BOUND_W'(d2_s2) < best_q)) begin
					best_q     <= BOUND_W'(d2_s2);
					best_idx_q <= idx_s2;
					found_q    <= 1'b1;
				end
			end
			if (cmd.sq_init) begin
				sq_cnt_q <= '0;
			end else if (cmd.sq_step) begin
				sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
			end
			if (cmd.acc) begin
				total_q <= tot_next;
				pos_x_q <= item_q.coord_x;
				pos_y_q <= item_q.coord_y;
			end
		end
	end

	// result beat
	assign idx_wide = {{IDX_OUT_W{1'b0}}, best_idx_q};

	always_comb begin
		res_d           = '0;
		res_d.travelled = total_q;
		case (item_q.op)
			OP_LOAD: begin
				res_d.table_full = full;
			end
			OP_MOVE: begin
				res_d.travelled = tot_next;
			end
			OP_VISIT: begin
				if (found_q) begin
					res_d.found           = 1'b1;
					res_d.nearest_index   = idx_wide[IDX_OUT_W-1:0];
					res_d.nearest_dist_sq = best_q[DIST_OUT_W-1:0];
					res_d.marked_visited  = hit_zero;
				end
			end
			OP_CLEAR: begin
				res_d = res_d;
			end
			default: begin
				res_d = res_d;
			end
		endcase
	end

endmodule

### rtl/core/nearest_unvisited_point_search.sv
// top level of the nearest unvisited point search block
// depends on nups_pkg, nups_ctrl and nups_dp
//
// usage
//   command beat: item (op, coord_x, coord_y) is taken at a rising edge with
//   start high and busy low; busy stays high until the beat's result is out
//   result beat: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so it must take every result as it comes
//   config: cfg_we writes cfg_wdata into the search bound; only while idle
//   steps per command, from accept to done:
//     load, clear  one write or clear step, then the result
//     move         distance, root setup, the 17-step bit-per-cycle root
//     visit        one table read per cycle through the single read port,
//                  then the pipeline drain; no scan when empty
//   the next command can be taken in the cycle that done is shown
//   reset: table empty, position and travelled total zero, bound 20000;
//   the point memories hold no reset value and are only read below the
//   entry count, so no clearing pass is needed
module nearest_unvisited_point_search #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  nups_pkg::in_item_t           item,
	input  logic                         cfg_we,
	input  logic [nups_pkg::BOUND_W-1:0] cfg_wdata,
	output logic                         done,
	output nups_pkg::result_t            result
);
	import nups_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: one command at a time
	nups_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.in_op  (item.op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// table, scan pipeline, root unit and result register
	nups_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.done      (done),
		.result    (result)
	);

	// every command ends with exactly one result beat
	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command finished without a result beat");

	// results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in a row");

	// a marked point must be a found point at distance zero
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.marked_visited) |->
			(result.found && (result.nearest_dist_sq == '0)))
		else $error("point marked at nonzero distance");

	// a dropped load never reports a visit
	a_full_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.table_full) |-> !result.found)
		else $error("table full flagged on a visit result");

endmodule
